FILE: design/key_press_classifier_defines.svh
// assertion macros for the key press classifier
// used by the top level; needs nothing else
`ifndef KEY_PRESS_CLASSIFIER_DEFINES_SVH
`define KEY_PRESS_CLASSIFIER_DEFINES_SVH

// same-cycle implication, disabled while reset is low
`define KPC_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("key_press_classifier: check failed");

// next-cycle implication, disabled while reset is low
`define KPC_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("key_press_classifier: check failed");

`endif

FILE: design/kpc_pkg.sv
// shared types and constants for the key press classifier
// no dependencies
`default_nettype none

package kpc_pkg;

  localparam int unsigned SCAN_LINES   = 6;
  localparam int unsigned RETURN_LINES = 8;
  localparam int unsigned NUM_KEYS     = SCAN_LINES * RETURN_LINES;
  localparam int unsigned ADDR_W       = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;

  localparam int unsigned KEY_W      = 6;
  localparam int unsigned TS_W       = 32;
  localparam int unsigned MASK_BITS  = 48;
  localparam int unsigned CFG_IDX_W  = 4;
  localparam int unsigned CFG_DATA_W = 48;

  localparam logic [TS_W-1:0]      LONG_PRESS_RST  = 32'd500;
  localparam logic [TS_W-1:0]      RELEASE_MIN_RST = 32'd100;
  localparam logic [MASK_BITS-1:0] KEY_MASK_RST    = 48'd151456011897289;
  localparam logic [KEY_W-1:0]     DOWN_ONLY_RST   = 6'd40;

  localparam logic [CFG_IDX_W-1:0] REG_LONG_PRESS  = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RELEASE_MIN = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_MASK    = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DOWN_ONLY   = 4'd3;

  typedef enum logic [1:0] {
    KIND_DOWN = 2'd0,
    KIND_UP   = 2'd1,
    KIND_LONG = 2'd2
  } kind_t;

  typedef struct packed {
    logic [TS_W-1:0]      long_press_ms;
    logic [TS_W-1:0]      release_min_ms;
    logic [MASK_BITS-1:0] key_present_mask;
    logic [KEY_W-1:0]     down_only_key;
  } cfg_t;

  typedef struct packed {
    logic [KEY_W-1:0] key_index;
    logic             pressed;
    logic [TS_W-1:0]  now_ms;
  } item_t;

  typedef struct packed {
    logic  ev_vld;
    kind_t ev_kind;
    logic  stamp_we;
    logic  flag_we;
    logic  held;
    logic  lng;
  } upd_t;

endpackage

`default_nettype wire

FILE: design/kpc_ram.sv
// generic single-write, single-read ram with registered read data
// no dependencies
`default_nettype none

module kpc_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 48
) (
  input  wire logic                                       clk,
  input  wire logic                                       we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                           wdata,
  input  wire logic                                       re,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                           rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

FILE: design/kpc_cfg_regs.sv
// configuration register file of the key press classifier
// depends on kpc_pkg
`default_nettype none

module kpc_cfg_regs (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             wr_en,
  input  wire logic [kpc_pkg::CFG_IDX_W-1:0]    wr_index,
  input  wire logic [kpc_pkg::CFG_DATA_W-1:0]   wr_data,
  output kpc_pkg::cfg_t                         cfg
);

  kpc_pkg::cfg_t cfg_r, cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (wr_index)
        kpc_pkg::REG_LONG_PRESS:  cfg_nxt.long_press_ms    = wr_data[kpc_pkg::TS_W-1:0];
        kpc_pkg::REG_RELEASE_MIN: cfg_nxt.release_min_ms   = wr_data[kpc_pkg::TS_W-1:0];
        kpc_pkg::REG_KEY_MASK:    cfg_nxt.key_present_mask = wr_data[kpc_pkg::MASK_BITS-1:0];
        kpc_pkg::REG_DOWN_ONLY:   cfg_nxt.down_only_key    = wr_data[kpc_pkg::KEY_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.long_press_ms    <= kpc_pkg::LONG_PRESS_RST;
      cfg_r.release_min_ms   <= kpc_pkg::RELEASE_MIN_RST;
      cfg_r.key_present_mask <= kpc_pkg::KEY_MASK_RST;
      cfg_r.down_only_key    <= kpc_pkg::DOWN_ONLY_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

`default_nettype wire

FILE: design/kpc_classify.sv
// per-key decision logic: down, up, long press or state clear
// depends on kpc_pkg
`default_nettype none

module kpc_classify (
  input  kpc_pkg::item_t                  item,
  input  wire logic [kpc_pkg::TS_W-1:0]   stamp,
  input  wire logic                       held,
  input  wire logic                       lng,
  input  kpc_pkg::cfg_t                   cfg,
  output kpc_pkg::upd_t                   upd
);

  logic [kpc_pkg::TS_W-1:0]      delta;
  logic [kpc_pkg::MASK_BITS-1:0] mask_sh;
  logic                          key_ok;

  always_comb begin
    upd      = '0;
    upd.held = held;
    upd.lng  = lng;
    upd.ev_kind = kpc_pkg::KIND_DOWN;
    delta    = item.now_ms - stamp;
    mask_sh  = cfg.key_present_mask >> item.key_index;
    key_ok   = (item.key_index < kpc_pkg::NUM_KEYS) &&
               (item.key_index < kpc_pkg::MASK_BITS) && mask_sh[0];

    if (key_ok) begin
      upd.flag_we = 1'b1;
      if (held && !lng) begin
        if (delta > cfg.long_press_ms) begin
          upd.lng     = 1'b1;
          upd.ev_vld  = 1'b1;
          upd.ev_kind = kpc_pkg::KIND_LONG;
        end else if (delta > cfg.release_min_ms && !item.pressed) begin
          upd.held    = 1'b0;
          upd.ev_vld  = 1'b1;
          upd.ev_kind = kpc_pkg::KIND_UP;
        end
      end else if (item.pressed && !lng) begin
        upd.held     = 1'b1;
        upd.stamp_we = 1'b1;
        upd.ev_vld   = 1'b1;
        upd.ev_kind  = kpc_pkg::KIND_DOWN;
      end else if (!item.pressed && lng) begin
        upd.held = 1'b0;
        upd.lng  = 1'b0;
      end
    end

    // down-only key keeps its state but reports nothing but presses
    if (upd.ev_vld && upd.ev_kind != kpc_pkg::KIND_DOWN &&
        item.key_index == cfg.down_only_key) begin
      upd.ev_vld = 1'b0;
    end
  end

endmodule

`default_nettype wire

FILE: design/key_press_classifier.sv
// top level of the key press classifier: handshakes, key state, result register
// depends on kpc_pkg, kpc_ram, kpc_cfg_regs, kpc_classify, key_press_classifier_defines.svh
//
//   channel  direction  handshake            payload
//   in_      slave      in_tvalid/in_tready  in_tdata  key, pressed, now_ms
//   out_     master     out_tvalid/out_tready out_tdata key, out_tuser kind
//   cfg_     slave      cfg_valid/cfg_ready  cfg_index, cfg_data
//
// one item per cycle sustained while the result slot is free or drained; an item waits
// in stage one for the registered read of the press stamp ram, then its event is offered
// from the result register; synchronous rst_n clears the held and long flags and valids
// and loads configuration defaults; a stalled result holds in the output register while
// the next item sits in stage one; cfg_ready is always high
`default_nettype none
`include "key_press_classifier_defines.svh"

module key_press_classifier (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  // in_tdata: key_index[5:0], pressed[6], now_ms[38:7], zero pad[39]
  input  wire logic                            in_tvalid,
  output logic                                 in_tready,
  input  wire logic [39:0]                     in_tdata,
  // out_tdata: event_key[5:0], zero pad[7:6]
  output logic                                 out_tvalid,
  input  wire logic                            out_tready,
  output logic      [7:0]                      out_tdata,
  // out_tuser: event_kind[1:0]
  output logic      [1:0]                      out_tuser,
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [kpc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [kpc_pkg::CFG_DATA_W-1:0]  cfg_data
);

  localparam int unsigned AW = kpc_pkg::ADDR_W;
  localparam int unsigned NK = kpc_pkg::NUM_KEYS;

  kpc_pkg::cfg_t  cfg;
  kpc_pkg::item_t in_item;
  kpc_pkg::upd_t  upd;

  // stage one: item register
  kpc_pkg::item_t s1_r, s1_nxt;
  logic           s1_vld_r, s1_vld_nxt;

  // forward path for a stamp written on the same edge as the ram read
  logic                     fwd_vld_r, fwd_vld_nxt;
  logic [kpc_pkg::KEY_W-1:0] fwd_key_r, fwd_key_nxt;
  logic [kpc_pkg::TS_W-1:0]  fwd_stamp_r, fwd_stamp_nxt;

  // per-key flags
  logic [NK-1:0] held_r, held_nxt;
  logic [NK-1:0] long_r, long_nxt;

  // result register
  logic                      out_vld_r, out_vld_nxt;
  logic [kpc_pkg::KEY_W-1:0] out_key_r, out_key_nxt;
  kpc_pkg::kind_t            out_kind_r, out_kind_nxt;

  logic                     in_acc;
  logic                     s1_adv;
  logic [AW-1:0]            rd_addr;
  logic [AW-1:0]            s1_addr;
  logic [kpc_pkg::TS_W-1:0] ram_rdata;
  logic [kpc_pkg::TS_W-1:0] stamp_eff;
  logic                     held_bit;
  logic                     long_bit;

  assign cfg_ready = 1'b1;

  assign in_item.key_index = in_tdata[5:0];
  assign in_item.pressed   = in_tdata[6];
  assign in_item.now_ms    = in_tdata[38:7];

  // stage one moves on whenever the result slot is free or being drained
  assign s1_adv    = s1_vld_r && (!out_vld_r || out_tready);
  assign in_tready = !s1_vld_r || s1_adv;
  assign in_acc    = in_tvalid && in_tready;

  // out-of-range keys read entry zero; the decision ignores them anyway
  assign rd_addr = (in_item.key_index < NK) ? AW'(in_item.key_index) : '0;
  assign s1_addr = (s1_r.key_index < NK) ? AW'(s1_r.key_index) : '0;

  kpc_cfg_regs u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  kpc_ram #(
    .WIDTH (kpc_pkg::TS_W),
    .DEPTH (NK)
  ) u_stamp_ram (
    .clk   (clk),
    .we    (s1_adv && upd.stamp_we),
    .waddr (s1_addr),
    .wdata (s1_r.now_ms),
    .re    (in_acc),
    .raddr (rd_addr),
    .rdata (ram_rdata)
  );

  // the ram read misses a write on its own edge, so take the forwarded stamp then
  assign stamp_eff = (fwd_vld_r && fwd_key_r == s1_r.key_index) ? fwd_stamp_r : ram_rdata;
  assign held_bit  = held_r[s1_addr];
  assign long_bit  = long_r[s1_addr];

  kpc_classify u_classify (
    .item  (s1_r),
    .stamp (stamp_eff),
    .held  (held_bit),
    .lng   (long_bit),
    .cfg   (cfg),
    .upd   (upd)
  );

  always_comb begin
    s1_nxt        = s1_r;
    s1_vld_nxt    = s1_vld_r;
    fwd_vld_nxt   = fwd_vld_r;
    fwd_key_nxt   = fwd_key_r;
    fwd_stamp_nxt = fwd_stamp_r;
    held_nxt      = held_r;
    long_nxt      = long_r;
    out_vld_nxt   = out_vld_r;
    out_key_nxt   = out_key_r;
    out_kind_nxt  = out_kind_r;

    // result slot drains, then may refill from stage one
    if (out_vld_r && out_tready) begin
      out_vld_nxt = 1'b0;
    end
    if (s1_adv) begin
      out_vld_nxt  = upd.ev_vld;
      out_key_nxt  = s1_r.key_index;
      out_kind_nxt = upd.ev_kind;
      if (upd.flag_we) begin
        held_nxt[s1_addr] = upd.held;
        long_nxt[s1_addr] = upd.lng;
      end
      s1_vld_nxt = 1'b0;
    end

    if (in_acc) begin
      s1_nxt        = in_item;
      s1_vld_nxt    = 1'b1;
      fwd_vld_nxt   = s1_adv && upd.stamp_we;
      fwd_key_nxt   = s1_r.key_index;
      fwd_stamp_nxt = s1_r.now_ms;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r  <= 1'b0;
      fwd_vld_r <= 1'b0;
      held_r    <= '0;
      long_r    <= '0;
      out_vld_r <= 1'b0;
    end else begin
      s1_vld_r  <= s1_vld_nxt;
      fwd_vld_r <= fwd_vld_nxt;
      held_r    <= held_nxt;
      long_r    <= long_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    s1_r        <= s1_nxt;
    fwd_key_r   <= fwd_key_nxt;
    fwd_stamp_r <= fwd_stamp_nxt;
    out_key_r   <= out_key_nxt;
    out_kind_r  <= out_kind_nxt;
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {2'b00, out_key_r};
  assign out_tuser  = out_kind_r;

  // a key never carries a long flag without being held
  `KPC_ASSERT_IMP(a_long_needs_held, clk, rst_n, 1'b1, (long_r & ~held_r) == '0)
  // an empty result slot never blocks the input
  `KPC_ASSERT_IMP(a_ready_when_empty, clk, rst_n, !out_vld_r, in_tready)
  // results only name real matrix keys
  `KPC_ASSERT_IMP(a_out_key_range, clk, rst_n, out_vld_r, out_key_r < NK)
  // a stage-one item that cannot move on stays as it is
  `KPC_ASSERT_NXT(a_s1_holds, clk, rst_n, s1_vld_r && !s1_adv, s1_vld_r && $stable(s1_r))

endmodule

`default_nettype wire
